// File: rtl/leb_pkg.sv
// shared constants and types for the line edit buffer
package leb_pkg;

  // line geometry
  localparam int unsigned Capacity = 64;
  localparam int unsigned PosW     = 6;
  localparam int unsigned LenW     = 7;
  localparam int unsigned CharW    = 8;

  // key codes
  localparam logic [CharW-1:0] TermCode  = 8'h76;
  localparam logic [CharW-1:0] CtrlLow   = 8'h70;
  localparam logic [CharW-1:0] CtrlHigh  = 8'h77;
  localparam logic [CharW-1:0] KeyLeft   = 8'h72;
  localparam logic [CharW-1:0] KeyRight  = 8'h73;
  localparam logic [CharW-1:0] KeyDelete = 8'h77;

  // request kinds
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef logic [PosW-1:0]  pos_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [CharW-1:0] char_t;

endpackage

// File: rtl/leb_ram.sv
// generic single write port ram with one registered read port
module leb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/line_edit_buffer_top.sv
// top level of the line edit buffer: control, length and cursor, result register
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------------
//   request  | in_valid_i / in_stall_o   | kind_i, key_code_i, read_index_i
//   result   | out_valid_o / out_stall_i | line_length_o, cursor_pos_o, read_char_o,
//            |                           | changed_o
//
// one request at a time: an accepted request passes to the result state, which loads the
// result register; a read of a stored character first passes the read state, an insert
// that moves the tail the up-shift and insert states, and a delete that moves the tail
// the down-shift state. the tail moves one character per cycle through the single ram port pair.
// the terminator is not stored: it is implied at length - 1, so the ram needs no
// clearing after reset. a stalled result waits in the output register while the next
// request is already accepted and worked on.
module line_edit_buffer_top
  import leb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [CharW-1:0] key_code_i,
  input  logic [PosW-1:0]  read_index_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [LenW-1:0]  line_length_o,
  output logic [PosW-1:0]  cursor_pos_o,
  output logic [CharW-1:0] read_char_o,
  output logic             changed_o
);

  // control states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  len_t       len_q, len_d;
  pos_t       cur_q, cur_d;
  pos_t       addr_q, addr_d;
  pos_t       stop_q, stop_d;
  char_t      ch_q, ch_d;
  char_t      rchar_q, rchar_d;
  logic       chg_q, chg_d;

  logic  out_valid_q;
  len_t  out_len_q;
  pos_t  out_cur_q;
  char_t out_char_q;
  logic  out_chg_q;

  logic  ram_we, ram_re;
  pos_t  ram_waddr, ram_raddr;
  char_t ram_wdata, ram_rdata;

  logic  in_acc, out_free, out_load, is_ctrl;
  len_t  len_m1;
  pos_t  last_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_OUT) && out_free;

  // position of the implied terminator
  assign len_m1   = len_q - len_t'(1);
  assign last_idx = len_m1[PosW-1:0];
  assign is_ctrl  = (key_code_i >= CtrlLow) && (key_code_i <= CtrlHigh);

  // character store
  leb_ram #(
    .Width(CharW),
    .Depth(Capacity)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // request decode and shift sequencer
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    cur_d     = cur_q;
    addr_d    = addr_q;
    stop_d    = stop_q;
    ch_d      = ch_q;
    rchar_d   = rchar_q;
    chg_d     = chg_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rchar_d = '0;
          chg_d   = 1'b0;
          state_d = S_OUT;
          unique case (kind_i)
            KIND_KEY: begin
              if (!is_ctrl) begin
                // insert at the cursor when there is room
                if (len_q < len_t'(Capacity)) begin
                  len_d = len_q + len_t'(1);
                  cur_d = cur_q + pos_t'(1);
                  chg_d = 1'b1;
                  ch_d  = key_code_i;
                  if (cur_q == last_idx) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_q;
                    ram_wdata = key_code_i;
                  end else begin
                    ram_re    = 1'b1;
                    ram_raddr = last_idx - pos_t'(1);
                    addr_d    = last_idx - pos_t'(1);
                    stop_d    = cur_q;
                    state_d   = S_UP;
                  end
                end
              end else begin
                priority if (key_code_i == KeyLeft) begin
                  if (cur_q != '0) begin
                    cur_d = cur_q - pos_t'(1);
                    chg_d = 1'b1;
                  end
                end else if (key_code_i == KeyRight) begin
                  if (cur_q != last_idx) begin
                    cur_d = cur_q + pos_t'(1);
                    chg_d = 1'b1;
                  end
                end else if (key_code_i == KeyDelete) begin
                  // remove the character before the cursor
                  if (cur_q != '0) begin
                    len_d = len_m1;
                    cur_d = cur_q - pos_t'(1);
                    chg_d = 1'b1;
                    if (cur_q != last_idx) begin
                      ram_re    = 1'b1;
                      ram_raddr = cur_q;
                      addr_d    = cur_q;
                      stop_d    = last_idx - pos_t'(1);
                      state_d   = S_DN;
                    end
                  end
                end else begin
                  chg_d = 1'b0;
                end
              end
            end
            KIND_CLEAR: begin
              chg_d = (len_q != len_t'(1)) || (cur_q != '0);
              len_d = len_t'(1);
              cur_d = '0;
            end
            KIND_READ: begin
              priority if (read_index_i < last_idx) begin
                ram_re    = 1'b1;
                ram_raddr = read_index_i;
                state_d   = S_RD;
              end else if (read_index_i == last_idx) begin
                rchar_d = TermCode;
              end else begin
                rchar_d = '0;
              end
            end
            default: begin
              chg_d = 1'b0;
            end
          endcase
        end
      end
      // move the tail up one place, from the end down to the cursor
      S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q + pos_t'(1);
        ram_wdata = ram_rdata;
        if (addr_q == stop_q) begin
          state_d = S_INS;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_q - pos_t'(1);
          addr_d    = addr_q - pos_t'(1);
        end
      end
      // drop the new character into the gap
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = stop_q;
        ram_wdata = ch_q;
        state_d   = S_OUT;
      end
      // move the tail down one place, from the cursor up to the end
      S_DN: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q - pos_t'(1);
        ram_wdata = ram_rdata;
        if (addr_q == stop_q) begin
          state_d = S_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_q + pos_t'(1);
          addr_d    = addr_q + pos_t'(1);
        end
      end
      S_RD: begin
        rchar_d = ram_rdata;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= len_t'(1);
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
    end
  end

  // sequencer working registers
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    stop_q  <= stop_d;
    ch_q    <= ch_d;
    rchar_q <= rchar_d;
    chg_q   <= chg_d;
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_len_q  <= len_q;
      out_cur_q  <= cur_q;
      out_char_q <= rchar_q;
      out_chg_q  <= chg_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_length_o = out_len_q;
  assign cursor_pos_o  = out_cur_q;
  assign read_char_o   = out_char_q;
  assign changed_o     = out_chg_q;

  // cursor never passes the terminator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_t'(cur_q) < len_q)
    else $error("cursor beyond terminator");

  // length stays within the line capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) && (len_q <= len_t'(Capacity)))
    else $error("line length out of range");

  // a shift step never reads the entry it writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write collide");

  // a new result only comes from the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result loaded outside result state");

endmodule
